/* src/mwo_pkg.sv */
// ============================================================================
// mwo_pkg
// Shared widths, codes, reset values and default sizes for the mipmapped
// wavetable oscillator.
// ============================================================================
`default_nettype none

package mwo_pkg;

  // Field widths of the item and result channels
  localparam int unsigned FREQ_W   = 25;
  localparam int unsigned PHASE_W  = 32;
  localparam int unsigned TNUM_W   = 4;
  localparam int unsigned TADDR_W  = 12;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned SAMPLE_W = 17;

  // Configuration registers
  localparam int unsigned INV_RATE_W = 28;
  localparam int unsigned BASE_INC_W = 32;
  localparam int unsigned NUM_TBL_W  = 5;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_INV_RATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_INC   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_TABLES = 2'd2;

  localparam logic [INV_RATE_W-1:0] INV_RATE_RST   = 28'd22906492;
  localparam logic [BASE_INC_W-1:0] BASE_INC_RST   = 32'd3579139;
  localparam logic [NUM_TBL_W-1:0]  NUM_TABLES_RST = 5'd1;

  // Item command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;

  // Default sizes
  localparam int unsigned TABLE_LEN_DEF        = 4096;
  localparam int unsigned MAX_TABLES_DEF       = 16;
  localparam int unsigned INTERP_FRAC_BITS_DEF = 16;

endpackage

`default_nettype wire

/* src/mwo_ifs.sv */
// ============================================================================
// mwo channel interfaces
// Valid/ready channels for oscillator items and for output samples.
// ============================================================================
`default_nettype none

// Item channel: sample request or table word write
interface mwo_item_if import mwo_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [FREQ_W-1:0]         freq_q8;
  logic                      with_offset;
  logic [PHASE_W-1:0]        phase_offset;
  logic [TNUM_W-1:0]         table_number;
  logic [TADDR_W-1:0]        table_addr;
  logic signed [WORD_W-1:0]  table_word;

  modport source (
    output valid, command, freq_q8, with_offset, phase_offset,
           table_number, table_addr, table_word,
    input  ready
  );
  modport sink (
    input  valid, command, freq_q8, with_offset, phase_offset,
           table_number, table_addr, table_word,
    output ready
  );
endinterface

// Result channel: one output sample
interface mwo_result_if import mwo_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, sample, input ready);
  modport sink   (input valid, sample, output ready);
endinterface

`default_nettype wire

/* src/mipmapped_wavetable_oscillator.sv */
// ============================================================================
// mipmapped_wavetable_oscillator
// Band-limited wavetable oscillator: frequency to phase increment, table
// choice by increment, two-point interpolated reads, optional offset read.
// ============================================================================
// Usage:
//   items   : valid/ready transaction. command selects a table word write
//             (table_number, table_addr, table_word) or a sample request
//             (freq_q8, with_offset, phase_offset).
//   results : valid/ready transaction carrying one sample per sample request;
//             table writes produce nothing.
//   cfg_*   : write port for inv_rate, base_top_inc and num_tables; write only
//             while the block is idle.
// Sequence: a table write completes in the idle state. A sample request
//   runs from acceptance to the result register through two partial
//   products of the increment, the add and saturation, the threshold
//   compares, the table pick, then two reads of the single table memory
//   (each fetching two neighbor entries on its two read ports) and the
//   interpolation. A new item is taken in the cycle after the result is
//   loaded; sample requests are not overlapped.
// Stall: the result register holds a sample while the receiver stalls; the
//   next request is still taken and runs up to its last step, where it waits
//   for the register to free up.
// Reset: clears phase, the configuration registers and the handshake state.
//   The table memory is not cleared; it must be loaded before use.
// ============================================================================
`default_nettype none

module mipmapped_wavetable_oscillator
  import mwo_pkg::*;
#(
  parameter int unsigned TABLE_LEN        = TABLE_LEN_DEF,
  parameter int unsigned MAX_TABLES       = MAX_TABLES_DEF,
  parameter int unsigned INTERP_FRAC_BITS = INTERP_FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  mwo_item_if.sink                   items,
  mwo_result_if.source               results,
  input  wire logic                  cfg_wen,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // --------------------------------------------------------------------------
  // Sizes
  // --------------------------------------------------------------------------
  localparam int unsigned F         = INTERP_FRAC_BITS;
  localparam int unsigned MEM_DEPTH = MAX_TABLES * TABLE_LEN;
  localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);
  localparam int unsigned IDX_W     = $clog2(TABLE_LEN);
  localparam int unsigned POS_W     = PHASE_W + IDX_W;
  localparam int unsigned TBL_W     = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
  localparam int unsigned MASK_W    = (MAX_TABLES > 1) ? MAX_TABLES - 1 : 1;
  localparam int unsigned THR_W     = PHASE_W + MAX_TABLES;
  localparam int unsigned USED_W    = 6;
  localparam int unsigned HALF_W    = INV_RATE_W / 2;
  localparam int unsigned PART_W    = FREQ_W + HALF_W;
  localparam int unsigned PROD_W    = FREQ_W + INV_RATE_W;
  localparam int unsigned INC_SH    = 16;
  localparam int unsigned SH_W      = PROD_W - INC_SH;
  localparam int unsigned WT_W      = F + 1;
  localparam int unsigned MUL_W     = WORD_W + F + 2;
  localparam int unsigned SUM_W     = MUL_W + 1;

  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(TABLE_LEN - 1);
  localparam logic [ADDR_W-1:0] TL_A     = ADDR_W'(TABLE_LEN);
  localparam logic [WT_W-1:0]   WT_ONE   = WT_W'(1) << F;
  localparam logic [SUM_W-1:0]  RND      = SUM_W'(1) << (F - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_SUM, S_MASK, S_TBL, S_RDA, S_RDB, S_RDC, S_FIN
  } state_t;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t                      state;
  logic [INV_RATE_W-1:0]       inv_rate;
  logic [BASE_INC_W-1:0]       base_top_inc;
  logic [NUM_TBL_W-1:0]        num_tables;
  logic [PHASE_W-1:0]          phase;

  logic [FREQ_W-1:0]           freq;
  logic                        wofs;
  logic [PHASE_W-1:0]          pofs;
  logic [PART_W-1:0]           part_lo;
  logic [PART_W-1:0]           part_hi;
  logic [PHASE_W-1:0]          inc;
  logic [MASK_W-1:0]           mask;
  logic [ADDR_W-1:0]           tbl_base;
  logic [IDX_W-1:0]            idx0, nxt0, idx1, nxt1;
  logic [F-1:0]                frac0, frac1;
  logic signed [MUL_W-1:0]     m0, m1;
  logic signed [WORD_W-1:0]    s0;
  logic                        out_valid;
  logic signed [SAMPLE_W-1:0]  out_sample;

  // Table memory, two read ports with registered data
  logic signed [WORD_W-1:0]    mem [MEM_DEPTH];
  logic signed [WORD_W-1:0]    rd_a, rd_b;

  // --------------------------------------------------------------------------
  // Combinational
  // --------------------------------------------------------------------------
  logic                        in_acc;
  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_waddr;
  logic [ADDR_W-1:0]           ra_addr, rb_addr;
  logic [POS_W-1:0]            pos0, pos1;
  logic [PHASE_W-1:0]          ph1;
  logic [PROD_W-1:0]           prod;
  logic [SH_W-1:0]             prod_sh;
  logic [PHASE_W-1:0]          inc_c;
  logic [USED_W-1:0]           used;
  logic [MASK_W-1:0]           mask_c;
  logic [TBL_W-1:0]            tbl_c;
  logic [WT_W-1:0]             wt_a, wt_b;
  logic [F-1:0]                frac_sel;
  logic signed [SUM_W-1:0]     wsum;
  logic signed [SUM_W-1:0]     wshift;
  logic signed [WORD_W-1:0]    lerp;
  logic signed [SAMPLE_W-1:0]  result;
  logic                        out_free;

  assign items.ready    = (state == S_IDLE);
  assign in_acc         = items.valid && items.ready;
  assign results.valid  = out_valid;
  assign results.sample = out_sample;
  assign out_free       = !out_valid || results.ready;

  // Table write decode
  always_comb begin
    mem_we    = in_acc && (items.command == CMD_WRITE)
                && (32'(items.table_number) < MAX_TABLES)
                && (32'(items.table_addr) < TABLE_LEN);
    mem_waddr = ADDR_W'(items.table_number) * TL_A + ADDR_W'(items.table_addr);
  end

  // Table positions of the main and the offset phase
  always_comb begin
    ph1  = phase + pofs;
    pos0 = POS_W'(phase) * POS_W'(TABLE_LEN);
    pos1 = POS_W'(ph1) * POS_W'(TABLE_LEN);
  end

  // Increment: sum of partial products, shift, saturate below a full phase turn
  always_comb begin
    prod    = PROD_W'(part_lo) + (PROD_W'(part_hi) << HALF_W);
    prod_sh = prod[PROD_W-1:INC_SH];
    inc_c   = (prod_sh[SH_W-1:PHASE_W] != '0) ? '1 : prod_sh[PHASE_W-1:0];
  end

  // Threshold compares: thresholds grow with the table number
  always_comb begin
    if (num_tables == '0) begin
      used = USED_W'(1);
    end else if (USED_W'(num_tables) > USED_W'(MAX_TABLES)) begin
      used = USED_W'(MAX_TABLES);
    end else begin
      used = USED_W'(num_tables);
    end
    mask_c = '0;
    for (int t = 0; t < int'(MAX_TABLES) - 1; t++) begin
      mask_c[t] = (USED_W'(t + 1) < used)
                  && (THR_W'(inc) >= (THR_W'(base_top_inc) << t));
    end
  end

  // Table pick: the mask is a thermometer, so its top set bit decides
  always_comb begin
    tbl_c = '0;
    for (int t = 0; t < int'(MAX_TABLES) - 1; t++) begin
      if (mask[t]) begin
        tbl_c = TBL_W'(t + 1);
      end
    end
  end

  // Read addresses: main phase in S_RDA, offset phase afterwards
  always_comb begin
    if (state == S_RDA) begin
      ra_addr = tbl_base + ADDR_W'(idx0);
      rb_addr = tbl_base + ADDR_W'(nxt0);
    end else begin
      ra_addr = tbl_base + ADDR_W'(idx1);
      rb_addr = tbl_base + ADDR_W'(nxt1);
    end
  end

  // Interpolation weights and rounding of the weighted sum
  always_comb begin
    frac_sel = (state == S_RDB) ? frac0 : frac1;
    wt_b     = WT_W'(frac_sel);
    wt_a     = WT_ONE - wt_b;
    wsum     = SUM_W'(m0) + SUM_W'(m1);
    wshift   = (wsum + $signed(RND)) >>> F;
    lerp     = wshift[WORD_W-1:0];
    result   = SAMPLE_W'(s0) - (wofs ? SAMPLE_W'(lerp) : SAMPLE_W'(0));
  end

  // --------------------------------------------------------------------------
  // Table memory
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= items.table_word;
    end
    rd_a <= mem[ra_addr];
    rd_b <= mem[rb_addr];
  end

  // --------------------------------------------------------------------------
  // Control, configuration and datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      inv_rate     <= INV_RATE_RST;
      base_top_inc <= BASE_INC_RST;
      num_tables   <= NUM_TABLES_RST;
      phase        <= '0;
      out_valid    <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_wen) begin
        unique case (cfg_index)
          REG_INV_RATE:   inv_rate     <= cfg_data[INV_RATE_W-1:0];
          REG_BASE_INC:   base_top_inc <= cfg_data[BASE_INC_W-1:0];
          REG_NUM_TABLES: num_tables   <= cfg_data[NUM_TBL_W-1:0];
          default: ;
        endcase
      end

      // result taken; in the last step the register is reloaded there instead
      if (out_valid && results.ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc && (items.command == CMD_SAMPLE)) begin
            freq  <= items.freq_q8;
            wofs  <= items.with_offset;
            pofs  <= items.phase_offset;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          part_lo <= PART_W'(freq) * PART_W'(inv_rate[HALF_W-1:0]);
          part_hi <= PART_W'(freq) * PART_W'(inv_rate[INV_RATE_W-1:HALF_W]);
          idx0    <= pos0[POS_W-1:PHASE_W];
          frac0   <= pos0[PHASE_W-1 -: F];
          idx1    <= pos1[POS_W-1:PHASE_W];
          frac1   <= pos1[PHASE_W-1 -: F];
          state   <= S_SUM;
        end
        S_SUM: begin
          inc   <= inc_c;
          nxt0  <= (idx0 == IDX_LAST) ? '0 : idx0 + IDX_W'(1);
          nxt1  <= (idx1 == IDX_LAST) ? '0 : idx1 + IDX_W'(1);
          state <= S_MASK;
        end
        S_MASK: begin
          mask  <= mask_c;
          state <= S_TBL;
        end
        S_TBL: begin
          tbl_base <= ADDR_W'(tbl_c) * TL_A;
          state    <= S_RDA;
        end
        S_RDA: begin
          state <= S_RDB;
        end
        S_RDB: begin
          m0    <= MUL_W'(rd_a) * $signed(MUL_W'(wt_a));
          m1    <= MUL_W'(rd_b) * $signed(MUL_W'(wt_b));
          state <= S_RDC;
        end
        S_RDC: begin
          s0    <= lerp;
          m0    <= MUL_W'(rd_a) * $signed(MUL_W'(wt_a));
          m1    <= MUL_W'(rd_b) * $signed(MUL_W'(wt_b));
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_sample <= result;
            phase      <= phase + inc;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // phase moves only when a finished sample is loaded
  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    !(state == S_FIN && out_free) |=> $stable(phase))
    else $error("phase changed without a sample being loaded");

  // a new result only ever comes from the last step
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FIN)
    else $error("result register loaded outside the last step");

  // a blocked last step waits with its sample and phase intact
  a_fin_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && !out_free) |=> (state == S_FIN) && $stable(phase))
    else $error("last step left while the result register was full");

  // table words are written only between sample requests
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> (state == S_IDLE))
    else $error("table write started a sample request");

endmodule

`default_nettype wire
